// ===== src/tlwc_pkg.sv =====
// Shared types and constants for the two-level write-back cache unit.
// Field widths, configuration register indexes and the cost register set.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlwc_pkg;

    localparam int WORD_W    = 32;
    localparam int ADDR_W    = 32;
    localparam int WADDR_W   = 30;
    localparam int TIME_W    = 32;
    localparam int COST_W    = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_L1_RD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_L1_WR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_RD   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_WR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_RD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAM_WR = 3'd5;

    typedef struct packed {
        logic [COST_W-1:0] l1_rd;
        logic [COST_W-1:0] l1_wr;
        logic [COST_W-1:0] l2_rd;
        logic [COST_W-1:0] l2_wr;
        logic [COST_W-1:0] dram_rd;
        logic [COST_W-1:0] dram_wr;
    } cost_regs_t;

    localparam cost_regs_t COST_RESET = '{
        l1_rd:   10'd1,
        l1_wr:   10'd1,
        l2_rd:   10'd10,
        l2_wr:   10'd10,
        dram_rd: 10'd100,
        dram_wr: 10'd50
    };

endpackage

`default_nettype wire

// ===== src/tlwc_if.sv =====
// Request and response channel interfaces of the cache unit.
// Depends on nothing; widths follow the request and response fields.
`timescale 1ns / 1ps
`default_nettype none

interface tlwc_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [31:0] address;
    logic [31:0] write_data;

    modport source (output valid, output cmd, output address, output write_data,
                    input ready);
    modport sink   (input valid, input cmd, input address, input write_data,
                    output ready);
endinterface

interface tlwc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic [31:0] elapsed_time;
    logic        address_error;

    modport source (output valid, output read_data, output elapsed_time,
                    output address_error, input ready);
    modport sink   (input valid, input read_data, input elapsed_time,
                    input address_error, output ready);
endinterface

`default_nettype wire

// ===== src/tlwc_ram.sv =====
// Simple dual-port memory: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module tlwc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/tlwc_ctrl.sv =====
// Sequencer of the cache unit: L1, L2 and DRAM memories, one shared block
// mover, one stamp comparator and one time adder. Uses tlwc_pkg, tlwc_if
// and tlwc_ram. Sizes are assumed to be powers of two (DRAM_BLOCKS need not).
`timescale 1ns / 1ps
`default_nettype none

module tlwc_ctrl #(
    parameter int BLOCK_WORDS = 16,
    parameter int L1_LINES    = 256,
    parameter int L2_SETS     = 256,
    parameter int L2_WAYS     = 2,
    parameter int DRAM_BLOCKS = 1024
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tlwc_pkg::cost_regs_t costs,
    tlwc_req_if.sink             req,
    tlwc_rsp_if.source           rsp
);
    import tlwc_pkg::*;

    localparam int BW_W       = $clog2(BLOCK_WORDS);
    localparam int BN_W       = WADDR_W - BW_W;
    localparam int L1I_W      = $clog2(L1_LINES);
    localparam int L2S_W      = $clog2(L2_SETS);
    localparam int BLK_W      = $clog2(DRAM_BLOCKS);
    localparam int L1T_W      = (BLK_W > L1I_W) ? BLK_W - L1I_W : 1;
    localparam int L2T_W      = (BLK_W > L2S_W) ? BLK_W - L2S_W : 1;
    localparam int L2_LINES   = L2_SETS * L2_WAYS;
    localparam int L2L_W      = $clog2(L2_LINES);
    localparam int WAY_W      = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int DRAM_DEPTH = DRAM_BLOCKS * BLOCK_WORDS;
    localparam int DA_W       = $clog2(DRAM_DEPTH);
    localparam int L1D_DEPTH  = L1_LINES * BLOCK_WORDS;
    localparam int L1D_W      = $clog2(L1D_DEPTH);
    localparam int L2D_DEPTH  = L2_LINES * BLOCK_WORDS;
    localparam int L2D_W      = $clog2(L2D_DEPTH);
    localparam int CNT_MAX    = (BLOCK_WORDS > L2_WAYS) ? BLOCK_WORDS : L2_WAYS;
    localparam int CNT_W      = $clog2(CNT_MAX + 1);
    localparam int CLR_A      = (DRAM_DEPTH > L1_LINES) ? DRAM_DEPTH : L1_LINES;
    localparam int CLR_N      = (CLR_A > L2_LINES) ? CLR_A : L2_LINES;
    localparam int CLR_W      = $clog2(CLR_N);
    localparam int L1M_W      = 2 + L1T_W;
    localparam int L2M_W      = 2 + L2T_W + TIME_W;

    typedef enum logic [12:0] {
        S_CLEAR     = 13'b0000000000001,
        S_IDLE      = 13'b0000000000010,
        S_L1_META   = 13'b0000000000100,
        S_L1_CHK    = 13'b0000000001000,
        S_L1_NEXT   = 13'b0000000010000,
        S_L1_ACC    = 13'b0000000100000,
        S_L1_RDATA  = 13'b0000001000000,
        S_L2_SCAN   = 13'b0000010000000,
        S_L2_PICK   = 13'b0000100000000,
        S_L2_DECIDE = 13'b0001000000000,
        S_L2_META   = 13'b0010000000000,
        S_MOVE      = 13'b0100000000000,
        S_DONE      = 13'b1000000000000
    } state_t;

    typedef enum logic [2:0] {
        MV_L2_TO_DRAM,
        MV_DRAM_TO_L2,
        MV_L2_TO_BUF,
        MV_L1_TO_L2,
        MV_BUF_TO_L1
    } move_t;

    state_t               state_reg,  state_next;
    move_t                mv_reg,     mv_next;
    logic [CNT_W-1:0]     cnt_reg,    cnt_next;
    logic [CLR_W-1:0]     clr_reg,    clr_next;
    logic                 cmd_reg,    cmd_next;
    logic [WADDR_W-1:0]   waddr_reg,  waddr_next;
    logic [WORD_W-1:0]    wdata_reg,  wdata_next;
    logic                 hit1_reg,   hit1_next;
    logic [L1M_W-1:0]     vm1_reg,    vm1_next;
    logic [BN_W-1:0]      blk2_reg,   blk2_next;
    logic                 wr2_reg,    wr2_next;
    logic                 hitf_reg,   hitf_next;
    logic [WAY_W-1:0]     hitw_reg,   hitw_next;
    logic                 emptyf_reg, emptyf_next;
    logic [WAY_W-1:0]     emptyw_reg, emptyw_next;
    logic                 oldf_reg,   oldf_next;
    logic [WAY_W-1:0]     oldw_reg,   oldw_next;
    logic [TIME_W-1:0]    olds_reg,   olds_next;
    logic [L2L_W-1:0]     line_reg,   line_next;
    logic [L2M_W-1:0]     vm2_reg,    vm2_next;
    logic                 dirty2_reg, dirty2_next;
    logic [TIME_W-1:0]    time_reg,   time_next;
    logic [WORD_W-1:0]    res_data_reg, res_data_next;
    logic                 res_err_reg,  res_err_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_W-1:0]    out_data_reg,  out_data_next;
    logic [TIME_W-1:0]    out_time_reg,  out_time_next;
    logic                 out_err_reg,   out_err_next;

    logic                 l1d_we;
    logic [L1D_W-1:0]     l1d_waddr, l1d_raddr;
    logic [WORD_W-1:0]    l1d_wdata, l1d_rdata;
    logic                 l2d_we;
    logic [L2D_W-1:0]     l2d_waddr, l2d_raddr;
    logic [WORD_W-1:0]    l2d_wdata, l2d_rdata;
    logic                 dram_we;
    logic [DA_W-1:0]      dram_waddr, dram_raddr;
    logic [WORD_W-1:0]    dram_wdata, dram_rdata;
    logic                 buf_we;
    logic [BW_W-1:0]      buf_waddr, buf_raddr;
    logic [WORD_W-1:0]    buf_wdata, buf_rdata;
    logic                 l1m_we;
    logic [L1I_W-1:0]     l1m_waddr, l1m_raddr;
    logic [L1M_W-1:0]     l1m_wdata, l1m_rdata;
    logic                 l2m_we;
    logic [L2L_W-1:0]     l2m_waddr, l2m_raddr;
    logic [L2M_W-1:0]     l2m_wdata, l2m_rdata;

    logic [COST_W-1:0]    add_cost;
    logic [L1I_W-1:0]     idx;
    logic [BW_W-1:0]      off;
    logic [L1T_W-1:0]     l1tag;
    logic [L2S_W-1:0]     set2;
    logic [L2T_W-1:0]     tag2;
    logic [BW_W-1:0]      mv_roff, mv_woff;
    logic                 mv_wr;
    logic [WAY_W-1:0]     scan_way, pick_way;
    logic [L2L_W-1:0]     scan_line, pick_line;
    logic                 l2_miss;
    logic [BN_W-1:0]      vblk1, vblk2;
    logic                 in_range;

    assign idx       = waddr_reg[BW_W +: L1I_W];
    assign off       = waddr_reg[BW_W-1:0];
    assign l1tag     = waddr_reg[BW_W + L1I_W +: L1T_W];
    assign set2      = blk2_reg[L2S_W-1:0];
    assign tag2      = blk2_reg[L2S_W +: L2T_W];
    assign mv_roff   = cnt_reg[BW_W-1:0];
    assign mv_woff   = BW_W'(cnt_reg - CNT_W'(1));
    assign mv_wr     = (state_reg == S_MOVE) && (cnt_reg != '0);
    assign scan_way  = WAY_W'(cnt_reg - CNT_W'(1));
    assign scan_line = L2L_W'(int'(set2) * L2_WAYS + int'(cnt_reg));
    assign pick_way  = hitf_reg ? hitw_reg : (emptyf_reg ? emptyw_reg : oldw_reg);
    assign pick_line = L2L_W'(int'(set2) * L2_WAYS + int'(pick_way));
    assign l2_miss   = !l2m_rdata[L2M_W-1] || (l2m_rdata[TIME_W +: L2T_W] != tag2);
    assign vblk1     = BN_W'({vm1_reg[L1T_W-1:0], idx});
    assign vblk2     = BN_W'({vm2_reg[TIME_W +: L2T_W], set2});
    assign in_range  = {2'b00, req.address[ADDR_W-1:2]} < ADDR_W'(DRAM_DEPTH);

    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = out_data_reg;
    assign rsp.elapsed_time  = out_time_reg;
    assign rsp.address_error = out_err_reg;

    // Memory port selection.
    always_comb
    begin
        l1d_we     = 1'b0;
        l1d_waddr  = {idx, mv_woff};
        l1d_wdata  = buf_rdata;
        l1d_raddr  = {idx, mv_roff};
        l2d_we     = 1'b0;
        l2d_waddr  = {line_reg, mv_woff};
        l2d_wdata  = dram_rdata;
        l2d_raddr  = {line_reg, mv_roff};
        dram_we    = 1'b0;
        dram_waddr = DA_W'({vblk2[BLK_W-1:0], mv_woff});
        dram_wdata = l2d_rdata;
        dram_raddr = DA_W'({blk2_reg[BLK_W-1:0], mv_roff});
        buf_we     = 1'b0;
        buf_waddr  = mv_woff;
        buf_wdata  = l2d_rdata;
        buf_raddr  = mv_roff;
        l1m_we     = 1'b0;
        l1m_waddr  = idx;
        l1m_wdata  = {1'b1, (hit1_reg & vm1_reg[L1M_W-2]) | cmd_reg, l1tag};
        l1m_raddr  = idx;
        l2m_we     = 1'b0;
        l2m_waddr  = line_reg;
        l2m_wdata  = {1'b1, dirty2_reg, tag2, time_reg};
        l2m_raddr  = (state_reg == S_L2_PICK) ? pick_line : scan_line;

        unique case (state_reg)
            S_CLEAR:
            begin
                dram_we    = (int'(clr_reg) < DRAM_DEPTH);
                dram_waddr = DA_W'(clr_reg);
                dram_wdata = '0;
                l1m_we     = (int'(clr_reg) < L1_LINES);
                l1m_waddr  = L1I_W'(clr_reg);
                l1m_wdata  = '0;
                l2m_we     = (int'(clr_reg) < L2_LINES);
                l2m_waddr  = L2L_W'(clr_reg);
                l2m_wdata  = '0;
            end
            S_L1_ACC:
            begin
                l1d_raddr = {idx, off};
                l1d_waddr = {idx, off};
                l1d_wdata = wdata_reg;
                l1d_we    = cmd_reg;
                l1m_we    = 1'b1;
            end
            S_L2_META:
            begin
                l2m_we = 1'b1;
            end
            S_MOVE:
            begin
                case (mv_reg)
                    MV_L2_TO_DRAM: dram_we = mv_wr;
                    MV_DRAM_TO_L2: l2d_we  = mv_wr;
                    MV_L2_TO_BUF:  buf_we  = mv_wr;
                    MV_L1_TO_L2:
                    begin
                        l2d_we    = mv_wr;
                        l2d_wdata = l1d_rdata;
                    end
                    MV_BUF_TO_L1:  l1d_we  = mv_wr;
                    default:       ;
                endcase
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        mv_next        = mv_reg;
        cnt_next       = cnt_reg;
        clr_next       = clr_reg;
        cmd_next       = cmd_reg;
        waddr_next     = waddr_reg;
        wdata_next     = wdata_reg;
        hit1_next      = hit1_reg;
        vm1_next       = vm1_reg;
        blk2_next      = blk2_reg;
        wr2_next       = wr2_reg;
        hitf_next      = hitf_reg;
        hitw_next      = hitw_reg;
        emptyf_next    = emptyf_reg;
        emptyw_next    = emptyw_reg;
        oldf_next      = oldf_reg;
        oldw_next      = oldw_reg;
        olds_next      = olds_reg;
        line_next      = line_reg;
        vm2_next       = vm2_reg;
        dirty2_next    = dirty2_reg;
        res_data_next  = res_data_reg;
        res_err_next   = res_err_reg;
        out_valid_next = out_valid_reg & ~rsp.ready;
        out_data_next  = out_data_reg;
        out_time_next  = out_time_reg;
        out_err_next   = out_err_reg;
        add_cost       = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + CLR_W'(1);
                if (int'(clr_reg) == CLR_N - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next      = req.cmd;
                    waddr_next    = req.address[ADDR_W-1:2];
                    wdata_next    = req.write_data;
                    res_data_next = '0;
                    res_err_next  = !in_range;
                    state_next    = in_range ? S_L1_META : S_DONE;
                end
            end
            S_L1_META:
            begin
                state_next = S_L1_CHK;
            end
            S_L1_CHK:
            begin
                vm1_next  = l1m_rdata;
                hit1_next = l1m_rdata[L1M_W-1] && (l1m_rdata[L1T_W-1:0] == l1tag);
                if (l1m_rdata[L1M_W-1] && (l1m_rdata[L1T_W-1:0] == l1tag))
                begin
                    state_next = S_L1_ACC;
                end
                else
                begin
                    blk2_next   = waddr_reg[BW_W +: BN_W];
                    wr2_next    = 1'b0;
                    hitf_next   = 1'b0;
                    emptyf_next = 1'b0;
                    oldf_next   = 1'b0;
                    cnt_next    = '0;
                    state_next  = S_L2_SCAN;
                end
            end
            S_L1_NEXT:
            begin
                cnt_next = '0;
                if (vm1_reg[L1M_W-1] && vm1_reg[L1M_W-2])
                begin
                    blk2_next   = vblk1;
                    wr2_next    = 1'b1;
                    hitf_next   = 1'b0;
                    emptyf_next = 1'b0;
                    oldf_next   = 1'b0;
                    state_next  = S_L2_SCAN;
                end
                else
                begin
                    mv_next    = MV_BUF_TO_L1;
                    state_next = S_MOVE;
                end
            end
            S_L1_ACC:
            begin
                add_cost   = cmd_reg ? costs.l1_wr : costs.l1_rd;
                state_next = cmd_reg ? S_DONE : S_L1_RDATA;
            end
            S_L1_RDATA:
            begin
                res_data_next = l1d_rdata;
                state_next    = S_DONE;
            end
            S_L2_SCAN:
            begin
                // examine the way read in the previous cycle
                if (cnt_reg != '0)
                begin
                    if (!l2m_rdata[L2M_W-1])
                    begin
                        emptyf_next = 1'b1;
                        emptyw_next = scan_way;
                    end
                    else if (l2m_rdata[TIME_W +: L2T_W] != tag2)
                    begin
                        if (!oldf_reg || (l2m_rdata[TIME_W-1:0] < olds_reg))
                        begin
                            oldf_next = 1'b1;
                            oldw_next = scan_way;
                            olds_next = l2m_rdata[TIME_W-1:0];
                        end
                    end
                    else
                    begin
                        hitf_next = 1'b1;
                        hitw_next = scan_way;
                    end
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (int'(cnt_reg) == L2_WAYS)
                begin
                    state_next = S_L2_PICK;
                end
            end
            S_L2_PICK:
            begin
                line_next  = pick_line;
                state_next = S_L2_DECIDE;
            end
            S_L2_DECIDE:
            begin
                vm2_next    = l2m_rdata;
                dirty2_next = l2_miss ? wr2_reg : (l2m_rdata[L2M_W-2] | wr2_reg);
                cnt_next    = '0;
                if (l2_miss)
                begin
                    add_cost   = costs.dram_rd;
                    state_next = S_MOVE;
                    mv_next    = (l2m_rdata[L2M_W-1] && l2m_rdata[L2M_W-2]) ?
                                 MV_L2_TO_DRAM : MV_DRAM_TO_L2;
                end
                else
                begin
                    state_next = S_L2_META;
                end
            end
            S_L2_META:
            begin
                cnt_next   = '0;
                mv_next    = wr2_reg ? MV_L1_TO_L2 : MV_L2_TO_BUF;
                state_next = S_MOVE;
            end
            S_MOVE:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (int'(cnt_reg) == BLOCK_WORDS)
                begin
                    cnt_next = '0;
                    case (mv_reg)
                        MV_L2_TO_DRAM:
                        begin
                            add_cost = costs.dram_wr;
                            mv_next  = MV_DRAM_TO_L2;
                        end
                        MV_DRAM_TO_L2: state_next = S_L2_META;
                        MV_L2_TO_BUF:
                        begin
                            add_cost   = costs.l2_rd;
                            state_next = S_L1_NEXT;
                        end
                        MV_L1_TO_L2:
                        begin
                            add_cost = costs.l2_wr;
                            mv_next  = MV_BUF_TO_L1;
                        end
                        MV_BUF_TO_L1:  state_next = S_L1_ACC;
                        default:       state_next = S_IDLE;
                    endcase
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_data_reg;
                    out_time_next  = time_reg;
                    out_err_next   = res_err_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        time_next = time_reg + TIME_W'(add_cost);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            cnt_reg       <= '0;
            mv_reg        <= MV_L2_TO_BUF;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            cnt_reg       <= cnt_next;
            mv_reg        <= mv_next;
            time_reg      <= time_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        waddr_reg    <= waddr_next;
        wdata_reg    <= wdata_next;
        hit1_reg     <= hit1_next;
        vm1_reg      <= vm1_next;
        blk2_reg     <= blk2_next;
        wr2_reg      <= wr2_next;
        hitf_reg     <= hitf_next;
        hitw_reg     <= hitw_next;
        emptyf_reg   <= emptyf_next;
        emptyw_reg   <= emptyw_next;
        oldf_reg     <= oldf_next;
        oldw_reg     <= oldw_next;
        olds_reg     <= olds_next;
        line_reg     <= line_next;
        vm2_reg      <= vm2_next;
        dirty2_reg   <= dirty2_next;
        res_data_reg <= res_data_next;
        res_err_reg  <= res_err_next;
        out_data_reg <= out_data_next;
        out_time_reg <= out_time_next;
        out_err_reg  <= out_err_next;
    end

    tlwc_ram #(.DEPTH(L1D_DEPTH), .WIDTH(WORD_W)) u_l1_data (
        .clk(clk), .we(l1d_we), .waddr(l1d_waddr), .wdata(l1d_wdata),
        .raddr(l1d_raddr), .rdata(l1d_rdata)
    );

    tlwc_ram #(.DEPTH(L1_LINES), .WIDTH(L1M_W)) u_l1_meta (
        .clk(clk), .we(l1m_we), .waddr(l1m_waddr), .wdata(l1m_wdata),
        .raddr(l1m_raddr), .rdata(l1m_rdata)
    );

    tlwc_ram #(.DEPTH(L2D_DEPTH), .WIDTH(WORD_W)) u_l2_data (
        .clk(clk), .we(l2d_we), .waddr(l2d_waddr), .wdata(l2d_wdata),
        .raddr(l2d_raddr), .rdata(l2d_rdata)
    );

    tlwc_ram #(.DEPTH(L2_LINES), .WIDTH(L2M_W)) u_l2_meta (
        .clk(clk), .we(l2m_we), .waddr(l2m_waddr), .wdata(l2m_wdata),
        .raddr(l2m_raddr), .rdata(l2m_rdata)
    );

    tlwc_ram #(.DEPTH(DRAM_DEPTH), .WIDTH(WORD_W)) u_dram (
        .clk(clk), .we(dram_we), .waddr(dram_waddr), .wdata(dram_wdata),
        .raddr(dram_raddr), .rdata(dram_rdata)
    );

    tlwc_ram #(.DEPTH(BLOCK_WORDS), .WIDTH(WORD_W)) u_fill_buf (
        .clk(clk), .we(buf_we), .waddr(buf_waddr), .wdata(buf_wdata),
        .raddr(buf_raddr), .rdata(buf_rdata)
    );

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_time_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) || (state_reg == S_CLEAR) || (state_reg == S_DONE)
        |=> time_reg == $past(time_reg))
        else $error("time advanced outside an access");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_err_reg |-> out_data_reg == '0)
        else $error("refused request returned data");

    a_move_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |-> (int'(cnt_reg) <= BLOCK_WORDS))
        else $error("block mover ran past the block");

endmodule

`default_nettype wire

// ===== src/two_level_writeback_cache_unit.sv =====
// Top level of the two-level write-back cache unit: cost register file and
// the cache sequencer. Depends on tlwc_pkg, tlwc_if and tlwc_ctrl.
//
// channel | dir | handshake   | payload
// req     | in  | valid/ready | cmd, address, write_data
// rsp     | out | valid/ready | read_data, elapsed_time, address_error
// cfg     | in  | cfg_we      | cfg_index, cfg_data
//
// An L1 read hit passes through S_L1_RDATA, which a write skips; a refused
// address goes straight to S_DONE. Each block moved between memories goes
// through the single word mover, and each L2 lookup scans the ways of its set.
// After reset a clearing pass over DRAM and the L1 and L2 metadata runs
// before the first request is taken.
// A stalled response holds in its register; one request is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module two_level_writeback_cache_unit #(
    parameter int BLOCK_WORDS = 16,
    parameter int L1_LINES    = 256,
    parameter int L2_SETS     = 256,
    parameter int L2_WAYS     = 2,
    parameter int DRAM_BLOCKS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tlwc_req_if.sink                       req,
    tlwc_rsp_if.source                     rsp,
    input  logic                           cfg_we,
    input  logic [tlwc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tlwc_pkg::COST_W-1:0]    cfg_data
);
    import tlwc_pkg::*;

    cost_regs_t costs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            costs_reg <= COST_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_L1_RD:   costs_reg.l1_rd   <= cfg_data;
                CFG_L1_WR:   costs_reg.l1_wr   <= cfg_data;
                CFG_L2_RD:   costs_reg.l2_rd   <= cfg_data;
                CFG_L2_WR:   costs_reg.l2_wr   <= cfg_data;
                CFG_DRAM_RD: costs_reg.dram_rd <= cfg_data;
                CFG_DRAM_WR: costs_reg.dram_wr <= cfg_data;
                default:     ;
            endcase
        end
    end

    tlwc_ctrl #(
        .BLOCK_WORDS(BLOCK_WORDS),
        .L1_LINES   (L1_LINES),
        .L2_SETS    (L2_SETS),
        .L2_WAYS    (L2_WAYS),
        .DRAM_BLOCKS(DRAM_BLOCKS)
    ) u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .costs(costs_reg),
        .req  (req),
        .rsp  (rsp)
    );

endmodule

`default_nettype wire

// ===== bench/tb_two_level_writeback_cache_unit.sv =====
// Testbench for the two-level write-back cache unit: directed and random
// word reads and writes checked against an in-bench cache/DRAM predictor.
// Depends on tlwc_pkg, tlwc_if and two_level_writeback_cache_unit.
`timescale 1ns / 1ps

module tb_two_level_writeback_cache_unit;
    import tlwc_pkg::*;

    localparam int BW         = 16;
    localparam int L1N        = 256;
    localparam int L2S        = 256;
    localparam int L2W        = 2;
    localparam int DRAMB      = 1024;
    localparam int MAX_CYCLES = 3000000;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] elapsed_time;
        logic        address_error;
    } access_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COST_W-1:0]    cfg_data = '0;

    tlwc_req_if req ();
    tlwc_rsp_if rsp ();

    two_level_writeback_cache_unit u_top (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Predictor state
    bit [COST_W-1:0] cost_m [6];
    bit [31:0] p_l1_words [L1N*BW];
    bit [31:0] p_l1_tags  [L1N];
    bit        p_l1_valid [L1N];
    bit        p_l1_dirty [L1N];
    bit [31:0] p_l2_words [L2S*L2W*BW];
    bit [31:0] p_l2_tags  [L2S*L2W];
    bit        p_l2_valid [L2S*L2W];
    bit        p_l2_dirty [L2S*L2W];
    bit [31:0] p_l2_stamp [L2S*L2W];
    bit [31:0] p_dram     [DRAMB*BW];
    bit [31:0] p_time;

    access_result_t expected_q [$];
    int unsigned errors = 0;
    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_cfg = 0;
    int unsigned n_addr_err = 0;
    int unsigned cycles = 0;
    int unsigned req_max_gap = 14;
    int unsigned rsp_max_gap = 14;
    int unsigned hold_len = 0;

    function automatic void dram_block(int unsigned blk, bit wr, ref bit [31:0] blk_data [BW]);
        int unsigned base;
        base = (blk % DRAMB) * BW;
        for (int i = 0; i < BW; i++) begin
            if (wr) p_dram[base+i] = blk_data[i];
            else blk_data[i] = p_dram[base+i];
        end
        p_time += wr ? cost_m[CFG_DRAM_WR] : cost_m[CFG_DRAM_RD];
    endfunction

    function automatic void l2_block(int unsigned blk, bit wr, ref bit [31:0] blk_data [BW]);
        int unsigned set, tag, base, line, k;
        int hit, empty, oldest;
        bit have_old;
        bit [31:0] oldest_stamp;
        bit [31:0] fresh [BW];
        bit [31:0] victim [BW];
        set = blk % L2S;
        tag = blk / L2S;
        base = set * L2W;
        hit = -1;
        empty = -1;
        oldest = 0;
        have_old = 0;
        oldest_stamp = 0;
        for (int w = 0; w < L2W; w++) begin
            k = base + w;
            if (!p_l2_valid[k]) empty = w;
            else if (p_l2_tags[k] != tag) begin
                if (!have_old || p_l2_stamp[k] < oldest_stamp) begin
                    have_old = 1;
                    oldest = w;
                    oldest_stamp = p_l2_stamp[k];
                end
            end
            else hit = w;
        end
        line = base + ((hit >= 0) ? hit : (empty >= 0) ? empty : oldest);
        if (!p_l2_valid[line] || p_l2_tags[line] != tag) begin
            dram_block(blk, 1'b0, fresh);
            if (p_l2_valid[line] && p_l2_dirty[line]) begin
                for (int i = 0; i < BW; i++) victim[i] = p_l2_words[line*BW+i];
                dram_block(p_l2_tags[line] * L2S + set, 1'b1, victim);
            end
            for (int i = 0; i < BW; i++) p_l2_words[line*BW+i] = fresh[i];
            p_l2_valid[line] = 1;
            p_l2_tags[line] = tag;
            p_l2_dirty[line] = 0;
        end
        p_l2_stamp[line] = p_time;
        if (wr) begin
            for (int i = 0; i < BW; i++) p_l2_words[line*BW+i] = blk_data[i];
            p_time += cost_m[CFG_L2_WR];
            p_l2_dirty[line] = 1;
        end
        else begin
            for (int i = 0; i < BW; i++) blk_data[i] = p_l2_words[line*BW+i];
            p_time += cost_m[CFG_L2_RD];
        end
    endfunction

    function automatic access_result_t predict_access(bit wr, bit [31:0] addr, bit [31:0] wdata);
        access_result_t r;
        bit [31:0] waddr;
        int unsigned blk, off, idx, tag;
        bit [31:0] fresh [BW];
        bit [31:0] victim [BW];
        waddr = addr >> 2;
        r = '0;
        if (waddr >= DRAMB * BW) begin
            r.elapsed_time = p_time;
            r.address_error = 1'b1;
            return r;
        end
        blk = waddr / BW;
        off = waddr % BW;
        idx = blk % L1N;
        tag = blk / L1N;
        if (!p_l1_valid[idx] || p_l1_tags[idx] != tag) begin
            l2_block(blk, 1'b0, fresh);
            if (p_l1_valid[idx] && p_l1_dirty[idx]) begin
                for (int i = 0; i < BW; i++) victim[i] = p_l1_words[idx*BW+i];
                l2_block(p_l1_tags[idx] * L1N + idx, 1'b1, victim);
            end
            for (int i = 0; i < BW; i++) p_l1_words[idx*BW+i] = fresh[i];
            p_l1_valid[idx] = 1;
            p_l1_tags[idx] = tag;
            p_l1_dirty[idx] = 0;
        end
        if (wr) begin
            p_l1_words[idx*BW+off] = wdata;
            p_time += cost_m[CFG_L1_WR];
            p_l1_dirty[idx] = 1;
        end
        else begin
            r.read_data = p_l1_words[idx*BW+off];
            p_time += cost_m[CFG_L1_RD];
        end
        r.elapsed_time = p_time;
        return r;
    endfunction

    // Called at a rising edge; returns at the edge that accepts the request.
    task automatic send_req(bit wr, bit [31:0] addr, bit [31:0] wdata);
        int unsigned gap;
        gap = $urandom_range(0, req_max_gap);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd <= wr;
        req.address <= addr;
        req.write_data <= wdata;
        do @(posedge clk); while (!(req.valid && req.ready));
        expected_q.push_back(predict_access(wr, addr, wdata));
        n_sent++;
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [COST_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx <= CFG_DRAM_WR) cost_m[idx] = val;
        n_cfg++;
        @(posedge clk);
    endtask

    // Mostly blocks that collide in a few L1 lines and L2 sets.
    function automatic bit [31:0] rand_address();
        int unsigned sel, idx, blk;
        sel = $urandom_range(0, 99);
        if (sel < 8) return $urandom() | 32'h0001_0000;
        if (sel < 25) return $urandom_range(0, 32'h0000_FFFF);
        case ($urandom_range(0, 3))
            0: idx = 0;
            1: idx = 1;
            2: idx = L1N - 1;
            default: idx = $urandom_range(0, L1N - 1);
        endcase
        blk = $urandom_range(0, 3) * L1N + idx;
        return blk * BW * 4 + $urandom_range(0, BW - 1) * 4 + $urandom_range(0, 3);
    endfunction

    task automatic run_random(int unsigned count);
        for (int i = 0; i < count; i++)
            send_req($urandom_range(0, 1), rand_address(), $urandom());
    endtask

    task automatic test_directed();
        send_req(1'b0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_req(1'b1, 32'h0000_0003, 32'hFFFF_FFFF);
        send_req(1'b0, 32'h0000_0000, 32'h0);
        send_req(1'b1, 32'h0000_FFFC, 32'hA5A5_5A5A);
        send_req(1'b0, 32'h0000_FFFF, 32'h0);
        send_req(1'b0, 32'h0001_0000, 32'h0);
        send_req(1'b1, 32'hFFFF_FFFF, 32'h1234_5678);
        send_req(1'b0, 32'h8000_0000, 32'h0);
        // Same L1 line, four tags: dirty L1 victims, then L2 set overflow.
        send_req(1'b1, 32'h0000_4004, 32'h0000_0001);
        send_req(1'b1, 32'h0000_8008, 32'h0000_0002);
        send_req(1'b1, 32'h0000_C00C, 32'h0000_0003);
        send_req(1'b1, 32'h0000_0010, 32'h0000_0004);
        send_req(1'b0, 32'h0000_4004, 32'h0);
        send_req(1'b0, 32'h0000_8008, 32'h0);
        send_req(1'b0, 32'h0000_C00C, 32'h0);
        send_req(1'b0, 32'h0000_0000, 32'h0);
        send_req(1'b0, 32'h0000_0010, 32'h0);
        send_req(1'b1, 32'h0000_3FC0, 32'h5555_AAAA);
        send_req(1'b0, 32'h0000_7FC0, 32'h0);
        send_req(1'b0, 32'h0000_3FC0, 32'h0);
        wait_idle();
    endtask

    task automatic test_cost_extremes();
        for (int i = 0; i <= CFG_DRAM_WR; i++) cfg_write(CFG_IDX_W'(i), 10'h3FF);
        run_random(60);
        wait_idle();
        for (int i = 0; i <= CFG_DRAM_WR; i++) cfg_write(CFG_IDX_W'(i), 10'h000);
        cfg_write(3'd6, 10'h155);
        cfg_write(3'd7, 10'h2AA);
        run_random(60);
        wait_idle();
        for (int i = 0; i <= CFG_DRAM_WR; i++) cfg_write(CFG_IDX_W'(i), 10'h001);
        run_random(60);
        wait_idle();
    endtask

    task automatic test_random_phases();
        for (int p = 0; p < 6; p++) begin
            for (int i = 0; i <= CFG_DRAM_WR; i++)
                cfg_write(CFG_IDX_W'(i), COST_W'($urandom_range(1, 1023)));
            // One phase runs both sides flat out.
            req_max_gap = (p == 2) ? 0 : 14;
            rsp_max_gap = (p == 2) ? 0 : 14;
            run_random(250);
            wait_idle();
        end
        req_max_gap = 14;
        rsp_max_gap = 14;
    endtask

    task automatic test_backpressure();
        req_max_gap = 0;
        hold_len = 600;
        run_random(40);
        req_max_gap = 14;
        wait_idle();
    endtask

    task automatic test_drain_pause();
        for (int i = 0; i < 8; i++) begin
            run_random(20);
            req.valid <= 1'b0;
            // Hold the next request until every pending response is back.
            while (expected_q.size() != 0) @(posedge clk);
        end
        for (int i = 0; i <= CFG_DRAM_WR; i++)
            cfg_write(CFG_IDX_W'(i), COST_W'(COST_RESET >> (COST_W * (5 - i))));
        run_random(80);
        wait_idle();
    endtask

    // Response ready with random stalls and a long hold-off on request.
    initial begin : rsp_ready_proc
        int unsigned n;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (hold_len > 0) begin
                rsp.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
                hold_len = 0;
            end
            n = $urandom_range(0, rsp_max_gap);
            if (n > 0) begin
                rsp.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!(rsp.valid && rsp.ready) && hold_len == 0);
        end
    end

    always @(posedge clk) begin : rsp_check
        access_result_t e;
        if (rst_n && rsp.valid && rsp.ready) begin
            if (expected_q.size() == 0) begin
                $error("unexpected response: read_data %h elapsed_time %h address_error %b",
                       rsp.read_data, rsp.elapsed_time, rsp.address_error);
                errors++;
            end
            else begin
                e = expected_q.pop_front();
                n_checked++;
                if (e.address_error) n_addr_err++;
                if (rsp.read_data !== e.read_data) begin
                    $error("read_data expected %h actual %h", e.read_data, rsp.read_data);
                    errors++;
                end
                if (rsp.elapsed_time !== e.elapsed_time) begin
                    $error("elapsed_time expected %h actual %h", e.elapsed_time,
                           rsp.elapsed_time);
                    errors++;
                end
                if (rsp.address_error !== e.address_error) begin
                    $error("address_error expected %b actual %b", e.address_error,
                           rsp.address_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("timeout after %0d cycles with %0d responses pending",
                     cycles, expected_q.size());
            $display("FAIL two_level_writeback_cache_unit");
            $finish;
        end
    end

    initial begin
        req.valid <= 1'b0;
        req.cmd <= 1'b0;
        req.address <= '0;
        req.write_data <= '0;
        for (int i = 0; i <= CFG_DRAM_WR; i++)
            cost_m[i] = COST_W'(COST_RESET >> (COST_W * (5 - i)));
        p_time = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_cost_extremes();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        wait_idle();
        repeat (200) @(posedge clk);
        if (expected_q.size() != 0) begin
            $error("%0d responses never arrived", expected_q.size());
            errors++;
        end
        $display("covered %0d requests (%0d out of DRAM range), %0d register writes,",
                 n_sent, n_addr_err, n_cfg);
        $display("L1/L2 conflict traffic, cost extremes, long response stall and drains");
        if (errors == 0)
            $display("PASS two_level_writeback_cache_unit");
        else
            $display("FAIL two_level_writeback_cache_unit");
        $finish;
    end

endmodule
